/* design/ksm_pkg.sv */
// ksm_pkg: shared types, constants and fixed-point helpers for the two-axis kalman smoother
// no dependencies; used by ksm_div, ksm_mul and two_axis_scalar_kalman_smoother_core
package ksm_pkg;

   // field widths
   localparam int SEQ_W   = 8;
   localparam int POS_W   = 24;
   localparam int EST_W   = 32;   // estimate, signed Q24.8
   localparam int VAR_W   = 20;   // variance and noise, unsigned Q4.16
   localparam int PVAR_W  = 21;   // predicted variance, Q5.16
   localparam int DEN_W   = 22;   // predicted variance plus measurement noise
   localparam int QUO_W   = 17;   // raw gain quotient, may reach 1.0
   localparam int GAIN_W  = 16;   // gain, Q0.16
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int STEP_W  = MUL_P_W - 16;

   // divider runs one quotient bit per cycle
   localparam int                DIV_STEPS = QUO_W;
   localparam logic [4:0]        DIV_LAST  = 5'(DIV_STEPS - 1);

   // constants of the filter
   localparam logic [SEQ_W-1:0]  GAP_LIMIT      = 8'd5;
   localparam logic [SEQ_W-1:0]  PREV_SEQ_RESET = 8'd50;
   localparam logic [VAR_W-1:0]  Q_RESET        = 20'd1311;
   localparam logic [VAR_W-1:0]  R_RESET        = 20'd13107;
   localparam logic [VAR_W-1:0]  VAR_ONE        = 20'h10000;
   localparam logic [VAR_W-1:0]  VAR_MAX        = 20'hFFFFF;
   localparam logic [QUO_W-1:0]  ONE_Q16        = 17'h10000;
   localparam logic [GAIN_W-1:0] GAIN_CAP       = 16'd64881;

   // configuration register indexes
   localparam logic CSR_PROCESS_NOISE = 1'b0;
   localparam logic CSR_MEASURE_NOISE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_MUL_E,
      ST_EST,
      ST_VAR,
      ST_DONE
   } ksm_state_type;

   // saturate a 37-bit signed sum into the 32-bit estimate range
   function automatic logic signed [EST_W-1:0] sat_est(input logic signed [EST_W+4:0] v);
      logic [5:0] top;
      top = v[EST_W+4:EST_W-1];
      if ((top == 6'h00) || (top == 6'h3F)) begin
         sat_est = v[EST_W-1:0];
      end else if (v[EST_W+4]) begin
         sat_est = {1'b1, {(EST_W-1){1'b0}}};
      end else begin
         sat_est = {1'b0, {(EST_W-1){1'b1}}};
      end
   endfunction

   // round Q24.8 to nearest integer (halves up) and saturate to the position range
   function automatic logic signed [POS_W-1:0] round_out(input logic signed [EST_W-1:0] e);
      logic signed [EST_W:0] r;
      logic signed [POS_W:0] q;
      r = {e[EST_W-1], e} + 33'sd128;
      q = r[EST_W:8];
      if (q[POS_W] == q[POS_W-1]) begin
         round_out = q[POS_W-1:0];
      end else if (q[POS_W]) begin
         round_out = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         round_out = {1'b0, {(POS_W-1){1'b1}}};
      end
   endfunction

   // saturate the new variance to its 20-bit range
   function automatic logic [VAR_W-1:0] sat_var(input logic [DEN_W-1:0] v);
      if (v[DEN_W-1:VAR_W] != 2'b00) begin
         sat_var = VAR_MAX;
      end else begin
         sat_var = v[VAR_W-1:0];
      end
   endfunction

endpackage

/* design/ksm_div.sv */
// ksm_div: restoring divider for the gain, quotient = floor(p * 2^16 / den), one bit per cycle
// depends on ksm_pkg; requires p <= den, which holds since the noise term is never negative
module ksm_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ksm_pkg::PVAR_W-1:0]     dividend,
   input  logic [ksm_pkg::DEN_W-1:0]      divisor,
   output logic                           done,
   output logic [ksm_pkg::QUO_W-1:0]      quotient
);

   logic [ksm_pkg::DEN_W:0]    rem_ff, rem_in;
   logic [ksm_pkg::DEN_W-1:0]  den_ff, den_in;
   logic [ksm_pkg::QUO_W-1:0]  quo_ff, quo_in;
   logic [4:0]                 cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [ksm_pkg::DEN_W:0]    shifted;
   logic                       fits;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      // first step compares the dividend itself, later steps shift in a zero
      shifted = (cnt_ff == 5'd0) ? rem_ff : {rem_ff[ksm_pkg::DEN_W-1:0], 1'b0};
      fits    = (shifted >= {1'b0, den_ff});
      if (start) begin
         rem_in  = {2'b00, dividend};
         den_in  = divisor;
         quo_in  = '0;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? (shifted - {1'b0, den_ff}) : shifted;
         quo_in = {quo_ff[ksm_pkg::QUO_W-2:0], fits};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == ksm_pkg::DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* design/ksm_mul.sv */
// ksm_mul: shared signed multiplier with registered product
// depends on ksm_pkg for operand widths
module ksm_mul (
   input  logic                                 clock,
   input  logic signed [ksm_pkg::MUL_A_W-1:0]   op_a,
   input  logic signed [ksm_pkg::MUL_B_W-1:0]   op_b,
   output logic signed [ksm_pkg::MUL_P_W-1:0]   product
);

   logic signed [ksm_pkg::MUL_P_W-1:0] prod_ff, prod_in;

   assign prod_in = ksm_pkg::MUL_P_W'(op_a) * ksm_pkg::MUL_P_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

/* design/two_axis_scalar_kalman_smoother_core.sv */
// two_axis_scalar_kalman_smoother_core: per-axis random-walk kalman filter on x,y position beats
// depends on ksm_pkg, ksm_div (gain divider) and ksm_mul (shared multiplier)
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_seq_number, req_meas_x, req_meas_y
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_est_x, rsp_est_y
//   csr     | in        | csr_write_en         | csr_index, csr_wdata (no wait, no read-back)
//
// a beat runs, per axis, the setup state, the divide state until all quotient bits are in and
// the divider's done is seen, and the multiply-error, estimate and variance states for the two
// passes through the shared multiplier, then the final state loads the result register
// req_ready is high only while the sequencer is idle; a finished result sits in the rsp
// register, so the next req beat may be accepted while it waits for rsp_ready; a result that
// finds the rsp register still full holds the sequencer in its final state
// synchronous active-high reset restores noise registers, sequence number, estimates, variances
module two_axis_scalar_kalman_smoother_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ksm_pkg::SEQ_W-1:0]           req_seq_number,
   input  logic signed [ksm_pkg::POS_W-1:0]    req_meas_x,
   input  logic signed [ksm_pkg::POS_W-1:0]    req_meas_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ksm_pkg::POS_W-1:0]    rsp_est_x,
   output logic signed [ksm_pkg::POS_W-1:0]    rsp_est_y,
   input  logic                                csr_write_en,
   input  logic                                csr_index,
   input  logic [ksm_pkg::VAR_W-1:0]           csr_wdata
);

   ksm_pkg::ksm_state_type state_ff, state_in;

   // configuration
   logic [ksm_pkg::VAR_W-1:0]          q_ff, q_in;
   logic [ksm_pkg::VAR_W-1:0]          r_ff, r_in;

   // filter state
   logic [ksm_pkg::SEQ_W-1:0]          prev_seq_ff, prev_seq_in;
   logic signed [ksm_pkg::EST_W-1:0]   est_x_ff, est_x_in;
   logic signed [ksm_pkg::EST_W-1:0]   est_y_ff, est_y_in;
   logic [ksm_pkg::VAR_W-1:0]          var_x_ff, var_x_in;
   logic [ksm_pkg::VAR_W-1:0]          var_y_ff, var_y_in;

   // per-beat working registers
   logic signed [ksm_pkg::POS_W-1:0]   meas_x_ff, meas_x_in;
   logic signed [ksm_pkg::POS_W-1:0]   meas_y_ff, meas_y_in;
   logic                               axis_ff, axis_in;
   logic [ksm_pkg::PVAR_W-1:0]         p_ff, p_in;
   logic                               den_zero_ff, den_zero_in;
   logic [ksm_pkg::GAIN_W-1:0]         gain_ff, gain_in;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [ksm_pkg::POS_W-1:0]   rsp_x_ff, rsp_x_in;
   logic signed [ksm_pkg::POS_W-1:0]   rsp_y_ff, rsp_y_in;

   // datapath wires
   logic signed [ksm_pkg::EST_W-1:0]   cur_est;
   logic [ksm_pkg::VAR_W-1:0]          cur_var;
   logic signed [ksm_pkg::POS_W-1:0]   cur_meas;
   logic [ksm_pkg::PVAR_W-1:0]         p_sum;
   logic [ksm_pkg::DEN_W-1:0]          den_sum;
   logic signed [ksm_pkg::EST_W:0]     err;
   logic signed [ksm_pkg::MUL_P_W-1:0] rounded;
   logic signed [ksm_pkg::STEP_W-1:0]  step;
   logic signed [ksm_pkg::EST_W+4:0]   est_sum;
   logic signed [ksm_pkg::EST_W-1:0]   est_new;
   logic [ksm_pkg::VAR_W-1:0]          var_new;
   logic [ksm_pkg::SEQ_W-1:0]          gap;
   logic                               accept;
   logic                               div_start;
   logic                               div_done;
   logic [ksm_pkg::QUO_W-1:0]          div_quo;
   logic signed [ksm_pkg::MUL_A_W-1:0] mul_a;
   logic signed [ksm_pkg::MUL_B_W-1:0] mul_b;
   logic signed [ksm_pkg::MUL_P_W-1:0] mul_p;
   logic [ksm_pkg::QUO_W-1:0]          one_minus_gain;

   ksm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (p_sum),
      .divisor  (den_sum),
      .done     (div_done),
      .quotient (div_quo)
   );

   ksm_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   assign accept = req_valid && req_ready;
   assign gap    = req_seq_number - prev_seq_ff;

   // axis select: x on the first pass, y on the second
   assign cur_est  = axis_ff ? est_y_ff  : est_x_ff;
   assign cur_var  = axis_ff ? var_y_ff  : var_x_ff;
   assign cur_meas = axis_ff ? meas_y_ff : meas_x_ff;

   // predicted variance and gain denominator, both exact
   assign p_sum   = {1'b0, cur_var} + {1'b0, q_ff};
   assign den_sum = {1'b0, p_sum} + {2'b00, r_ff};

   // innovation in Q24.8, 33 bits
   assign err = $signed({cur_meas[ksm_pkg::POS_W-1], cur_meas, 8'h00})
              - $signed({cur_est[ksm_pkg::EST_W-1], cur_est});

   // est += round(err * gain / 2^16), halves up; arithmetic part-select is the floor shift
   assign rounded = mul_p + ksm_pkg::MUL_P_W'(32768);
   assign step    = rounded[ksm_pkg::MUL_P_W-1:16];
   assign est_sum = {{5{cur_est[ksm_pkg::EST_W-1]}}, cur_est}
                  + {step[ksm_pkg::STEP_W-1], step};
   assign est_new = ksm_pkg::sat_est(est_sum);

   // var = floor((1 - gain) * p / 2^16), saturated
   assign var_new = ksm_pkg::sat_var(mul_p[16+ksm_pkg::DEN_W-1:16]);

   assign one_minus_gain = ksm_pkg::ONE_Q16 - {1'b0, gain_ff};

   // shared multiplier operand select
   always_comb begin
      if (state_ff == ksm_pkg::ST_MUL_E) begin
         mul_a = {err[ksm_pkg::EST_W], err};
         mul_b = {2'b00, gain_ff};
      end else begin
         mul_a = {{(ksm_pkg::MUL_A_W-ksm_pkg::PVAR_W){1'b0}}, p_ff};
         mul_b = {1'b0, one_minus_gain};
      end
   end

   // sequencer: next state and register updates
   always_comb begin
      state_in     = state_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      prev_seq_in  = prev_seq_ff;
      est_x_in     = est_x_ff;
      est_y_in     = est_y_ff;
      var_x_in     = var_x_ff;
      var_y_in     = var_y_ff;
      meas_x_in    = meas_x_ff;
      meas_y_in    = meas_y_ff;
      axis_in      = axis_ff;
      p_in         = p_ff;
      den_zero_in  = den_zero_ff;
      gain_in      = gain_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      div_start    = 1'b0;
      req_ready    = 1'b0;

      if (csr_write_en) begin
         unique case (csr_index)
            ksm_pkg::CSR_PROCESS_NOISE: q_in = csr_wdata;
            ksm_pkg::CSR_MEASURE_NOISE: r_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ksm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               meas_x_in   = req_meas_x;
               meas_y_in   = req_meas_y;
               prev_seq_in = req_seq_number;
               axis_in     = 1'b0;
               // long gap in the report stream: restart both axes from the measurement
               if (gap > ksm_pkg::GAP_LIMIT) begin
                  est_x_in = {req_meas_x, 8'h00};
                  est_y_in = {req_meas_y, 8'h00};
                  var_x_in = ksm_pkg::VAR_ONE;
                  var_y_in = ksm_pkg::VAR_ONE;
               end
               state_in = ksm_pkg::ST_PREP;
            end
         end
         ksm_pkg::ST_PREP: begin
            div_start   = 1'b1;
            p_in        = p_sum;
            den_zero_in = (den_sum == '0);
            state_in    = ksm_pkg::ST_DIV;
         end
         ksm_pkg::ST_DIV: begin
            if (div_done) begin
               // zero denominator or gain of one or more: cap at 0.99
               if (den_zero_ff || div_quo[ksm_pkg::QUO_W-1]) begin
                  gain_in = ksm_pkg::GAIN_CAP;
               end else begin
                  gain_in = div_quo[ksm_pkg::GAIN_W-1:0];
               end
               state_in = ksm_pkg::ST_MUL_E;
            end
         end
         ksm_pkg::ST_MUL_E: begin
            state_in = ksm_pkg::ST_EST;
         end
         ksm_pkg::ST_EST: begin
            if (axis_ff) begin
               est_y_in = est_new;
            end else begin
               est_x_in = est_new;
            end
            state_in = ksm_pkg::ST_VAR;
         end
         ksm_pkg::ST_VAR: begin
            if (axis_ff) begin
               var_y_in = var_new;
               state_in = ksm_pkg::ST_DONE;
            end else begin
               var_x_in = var_new;
               axis_in  = 1'b1;
               state_in = ksm_pkg::ST_PREP;
            end
         end
         ksm_pkg::ST_DONE: begin
            // load the result register once the previous beat has left
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_x_in     = ksm_pkg::round_out(est_x_ff);
               rsp_y_in     = ksm_pkg::round_out(est_y_ff);
               rsp_valid_in = 1'b1;
               state_in     = ksm_pkg::ST_IDLE;
            end
         end
         default: state_in = ksm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ksm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff         <= ksm_pkg::Q_RESET;
         r_ff         <= ksm_pkg::R_RESET;
         prev_seq_ff  <= ksm_pkg::PREV_SEQ_RESET;
         est_x_ff     <= '0;
         est_y_ff     <= '0;
         var_x_ff     <= ksm_pkg::VAR_ONE;
         var_y_ff     <= ksm_pkg::VAR_ONE;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         q_ff         <= q_in;
         r_ff         <= r_in;
         prev_seq_ff  <= prev_seq_in;
         est_x_ff     <= est_x_in;
         est_y_ff     <= est_y_in;
         var_x_ff     <= var_x_in;
         var_y_ff     <= var_y_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      meas_x_ff   <= meas_x_in;
      meas_y_ff   <= meas_y_in;
      p_ff        <= p_in;
      den_zero_ff <= den_zero_in;
      gain_ff     <= gain_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_est_x = rsp_x_ff;
   assign rsp_est_y = rsp_y_ff;

   // an accepted beat keeps the sequencer busy for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("req_ready high right after an accepted beat");

   // the divider only finishes while the sequencer waits for it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ksm_pkg::ST_DIV))
      else $error("divider finished outside the divide state");

   // a new result appears only out of the final state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ksm_pkg::ST_DONE))
      else $error("rsp_valid rose without a finished beat");

   // a beat always starts its first pass on the x axis
   a_axis_clear_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ksm_pkg::ST_PREP) && $past(state_ff == ksm_pkg::ST_IDLE) |-> !axis_ff)
      else $error("beat started on the wrong axis");

endmodule

/* test/two_axis_scalar_kalman_smoother_core_tb.sv */
// two_axis_scalar_kalman_smoother_core_tb: self-checking bench for the two-axis kalman smoother
// drives position beats and noise registers, predicts both filtered estimates in fixed point
// depends on ksm_pkg and two_axis_scalar_kalman_smoother_core
`timescale 1ns / 100ps

module two_axis_scalar_kalman_smoother_core_tb;

   localparam int     WATCHDOG_LIMIT = 2000;
   localparam int     TAIL_CYCLES    = 60;
   localparam longint EST_HI         = 64'sh7FFFFFFF;
   localparam longint EST_LO         = -64'sh80000000;
   localparam longint POS_HI         = 64'sh7FFFFF;
   localparam longint POS_LO         = -64'sh800000;

   typedef struct packed {
      logic signed [ksm_pkg::POS_W-1:0] x;
      logic signed [ksm_pkg::POS_W-1:0] y;
   } position_type;

   // dut signals
   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic [ksm_pkg::SEQ_W-1:0]        req_seq_number;
   logic signed [ksm_pkg::POS_W-1:0] req_meas_x;
   logic signed [ksm_pkg::POS_W-1:0] req_meas_y;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic signed [ksm_pkg::POS_W-1:0] rsp_est_x;
   logic signed [ksm_pkg::POS_W-1:0] rsp_est_y;
   logic                             csr_write_en;
   logic                             csr_index;
   logic [ksm_pkg::VAR_W-1:0]        csr_wdata;

   // filter state mirrored by the bench
   logic [ksm_pkg::VAR_W-1:0]        flt_q;
   logic [ksm_pkg::VAR_W-1:0]        flt_r;
   logic [ksm_pkg::SEQ_W-1:0]        flt_prev_seq;
   logic signed [ksm_pkg::EST_W-1:0] flt_est_x;
   logic signed [ksm_pkg::EST_W-1:0] flt_est_y;
   logic [ksm_pkg::VAR_W-1:0]        flt_var_x;
   logic [ksm_pkg::VAR_W-1:0]        flt_var_y;

   // estimates still owed by the block, oldest first
   position_type pending_estimates[$];

   int error_count    = 0;
   int reports_sent   = 0;
   int results_seen   = 0;
   int register_writes = 0;
   int reload_count   = 0;
   int clamp_count    = 0;
   int idle_cycles    = 0;
   int stall_left     = 0;
   bit steady         = 1'b0;   // set: neither side inserts gaps

   always #5 clock = ~clock;

   two_axis_scalar_kalman_smoother_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_seq_number (req_seq_number),
      .req_meas_x     (req_meas_x),
      .req_meas_y     (req_meas_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_est_x      (rsp_est_x),
      .rsp_est_y      (rsp_est_y),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // gap length: mostly none or short, now and then long
   function automatic int pick_idle();
      int r;
      if (steady) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 4);
      end
      return $urandom_range(10, 70);
   endfunction

   // one axis of the random-walk filter: predict, gain, correct, shrink variance
   task automatic smooth_axis(inout logic signed [ksm_pkg::EST_W-1:0] est,
                              inout logic [ksm_pkg::VAR_W-1:0] vr,
                              input logic signed [ksm_pkg::POS_W-1:0] meas);
      longint p;
      longint den;
      longint gain;
      longint err;
      longint nxt;
      longint nv;
      p   = longint'(vr) + longint'(flt_q);
      den = p + longint'(flt_r);
      if (den == 0) begin
         gain = longint'(ksm_pkg::GAIN_CAP);
         clamp_count++;
      end else begin
         gain = (p <<< 16) / den;
         // gain of one or more only when measurement noise is zero
         if (gain >= longint'(ksm_pkg::ONE_Q16)) begin
            gain = longint'(ksm_pkg::GAIN_CAP);
            clamp_count++;
         end
      end
      err = longint'(meas) * 256 - longint'(est);
      // round half up on the q16 product, arithmetic shift floors negatives
      nxt = longint'(est) + ((err * gain + 32768) >>> 16);
      if (nxt > EST_HI) begin
         nxt = EST_HI;
      end else if (nxt < EST_LO) begin
         nxt = EST_LO;
      end
      est = ksm_pkg::EST_W'(nxt);
      nv = ((longint'(ksm_pkg::ONE_Q16) - gain) * p) >>> 16;
      if (nv > longint'(ksm_pkg::VAR_MAX)) begin
         nv = longint'(ksm_pkg::VAR_MAX);
      end
      vr = ksm_pkg::VAR_W'(nv);
   endtask

   // q24.8 estimate to integer position, halves up, saturated
   function automatic logic signed [ksm_pkg::POS_W-1:0] round_position(
         input logic signed [ksm_pkg::EST_W-1:0] e);
      longint r;
      r = (longint'(e) + 128) >>> 8;
      if (r > POS_HI) begin
         r = POS_HI;
      end else if (r < POS_LO) begin
         r = POS_LO;
      end
      return ksm_pkg::POS_W'(r);
   endfunction

   // advance the mirrored filter by one accepted report and queue its estimate
   task automatic predict_estimates(input logic [ksm_pkg::SEQ_W-1:0] seq,
                                    input logic signed [ksm_pkg::POS_W-1:0] mx,
                                    input logic signed [ksm_pkg::POS_W-1:0] my);
      logic [ksm_pkg::SEQ_W-1:0] gap;
      position_type              want;
      gap = seq - flt_prev_seq;
      if (gap > ksm_pkg::GAP_LIMIT) begin
         // lost track: restart both axes from the measurement
         flt_est_x = {mx, 8'd0};
         flt_est_y = {my, 8'd0};
         flt_var_x = ksm_pkg::VAR_ONE;
         flt_var_y = ksm_pkg::VAR_ONE;
         reload_count++;
      end
      flt_prev_seq = seq;
      smooth_axis(flt_est_x, flt_var_x, mx);
      smooth_axis(flt_est_y, flt_var_y, my);
      want.x = round_position(flt_est_x);
      want.y = round_position(flt_est_y);
      pending_estimates.push_back(want);
   endtask

   // one position beat; valid stays up across back-to-back beats
   task automatic send_report(input logic [ksm_pkg::SEQ_W-1:0] seq,
                              input logic signed [ksm_pkg::POS_W-1:0] mx,
                              input logic signed [ksm_pkg::POS_W-1:0] my);
      int gap;
      gap = pick_idle();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_seq_number <= seq;
      req_meas_x     <= mx;
      req_meas_y     <= my;
      do @(posedge clock); while (!req_ready);
      predict_estimates(seq, mx, my);
      reports_sent++;
   endtask

   // stop sending and let every owed estimate come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_estimates.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // noise register write, only called with the block drained
   task automatic write_noise(input logic idx, input logic [ksm_pkg::VAR_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      if (idx == ksm_pkg::CSR_PROCESS_NOISE) begin
         flt_q = value;
      end else begin
         flt_r = value;
      end
      register_writes++;
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_noise(input logic [ksm_pkg::VAR_W-1:0] q,
                            input logic [ksm_pkg::VAR_W-1:0] r);
      wait_drained();
      write_noise(ksm_pkg::CSR_PROCESS_NOISE, q);
      write_noise(ksm_pkg::CSR_MEASURE_NOISE, r);
   endtask

   // random walk around the last position, with jumps anywhere and to the rails
   function automatic logic signed [ksm_pkg::POS_W-1:0] wander(
         input logic signed [ksm_pkg::POS_W-1:0] from);
      longint nxt;
      int     pick;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         return ksm_pkg::POS_W'($urandom);
      end
      if (pick < 6) begin
         return ksm_pkg::POS_W'(POS_HI);
      end
      if (pick < 8) begin
         return ksm_pkg::POS_W'(POS_LO);
      end
      nxt = longint'(from) + longint'($urandom_range(0, 4000)) - 2000;
      if (nxt > POS_HI) begin
         nxt = POS_HI;
      end else if (nxt < POS_LO) begin
         nxt = POS_LO;
      end
      return ksm_pkg::POS_W'(nxt);
   endfunction

   // mostly in-order numbering, some repeats, some gaps at and past the limit
   function automatic logic [ksm_pkg::SEQ_W-1:0] next_seq_number(
         input logic [ksm_pkg::SEQ_W-1:0] cur);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
         return cur + ksm_pkg::SEQ_W'($urandom_range(1, 2));
      end
      if (pick < 86) begin
         return cur;
      end
      if (pick < 94) begin
         return cur + ksm_pkg::SEQ_W'($urandom_range(3, 5));
      end
      return cur + ksm_pkg::SEQ_W'($urandom_range(6, 255));
   endfunction

   // sequence number handling against the reset value of the last number
   task automatic test_sequence_gaps();
      send_report(8'd50, 24'sd300, -24'sd300);       // repeat of reset number, no reload
      send_report(8'd51, 24'sd1000, -24'sd1000);
      send_report(8'd51, 24'sd1000, -24'sd1000);     // repeated number
      send_report(8'd56, 24'sd1010, -24'sd990);      // gap right at the limit
      send_report(8'd62, -24'sd5000, 24'sd7000);     // one past the limit
      send_report(8'd61, -24'sd5100, 24'sd7100);     // backward step wraps to a big gap
      send_report(8'd255, 24'sd17, -24'sd17);
      send_report(8'd0, 24'sd18, -24'sd18);          // wrap 255 to 0
   endtask

   // rails of the position fields, both directions
   task automatic test_position_rails();
      send_report(8'd1, 24'sh7FFFFF, 24'sh800000);
      send_report(8'd2, 24'sh800000, 24'sh7FFFFF);
      send_report(8'd3, 24'sh7FFFFF, 24'sh7FFFFF);
      send_report(8'd10, 24'sh800000, 24'sh800000);  // reload at the negative rail
      send_report(8'd11, 24'sh7FFFFF, 24'sh800000);
      send_report(8'd12, 24'sd0, 24'sd0);
   endtask

   // gain clamp: zero r caps the gain, zero q then drives the denominator to zero; then saturated noise
   task automatic test_gain_clamp();
      int i;
      set_noise(20'd0, 20'd0);
      for (i = 0; i < 5; i++) begin
         send_report(8'(20 + i), 24'(i * 4001), 24'(-i * 777));
      end
      set_noise(ksm_pkg::VAR_MAX, ksm_pkg::VAR_MAX);
      send_report(8'd40, 24'sd123456, -24'sd654321);
      send_report(8'd41, -24'sd3, 24'sd3);
      set_noise(20'd0, ksm_pkg::VAR_MAX);
      send_report(8'd42, 24'sd99, 24'sd99);
      send_report(8'd43, 24'sh7FFFFF, 24'sh800000);
   endtask

   // long randomized tracks under one noise setting
   task automatic run_track(input int beats, input bit hold_off);
      logic [ksm_pkg::SEQ_W-1:0]        seq;
      logic signed [ksm_pkg::POS_W-1:0] px;
      logic signed [ksm_pkg::POS_W-1:0] py;
      int                               i;
      seq = 8'($urandom);
      px  = ksm_pkg::POS_W'($urandom);
      py  = ksm_pkg::POS_W'($urandom);
      for (i = 0; i < beats; i++) begin
         seq = next_seq_number(seq);
         px  = wander(px);
         py  = wander(py);
         send_report(seq, px, py);
         if (hold_off && i == beats / 2) begin
            wait_drained();
         end
      end
   endtask

   task automatic test_random_tracks();
      set_noise(ksm_pkg::Q_RESET, ksm_pkg::R_RESET);
      run_track(100, 1'b1);
      set_noise(20'($urandom_range(0, 4000)), 20'($urandom_range(0, 40000)));
      run_track(95, 1'b0);
      // back-to-back beats with the receiver always ready
      steady = 1'b1;
      set_noise(ksm_pkg::VAR_MAX, 20'd0);
      run_track(90, 1'b0);
      steady = 1'b0;
      set_noise(20'd0, ksm_pkg::VAR_MAX);
      run_track(90, 1'b1);
      set_noise(20'($urandom), 20'($urandom));
      run_track(95, 1'b0);
      wait_drained();
   endtask

   // receiver: random stalls on the result channel
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 5) == 0) begin
            stall_left <= pick_idle();
         end
      end
   end

   // result check against the oldest owed estimate
   always @(posedge clock) begin
      position_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_estimates.size() == 0) begin
            $display("%0t unexpected result: x %0d y %0d", $time, rsp_est_x, rsp_est_y);
            error_count++;
         end else begin
            want = pending_estimates.pop_front();
            if (rsp_est_x !== want.x) begin
               $display("%0t est_x mismatch: expected %0d actual %0d",
                        $time, want.x, rsp_est_x);
               error_count++;
            end
            if (rsp_est_y !== want.y) begin
               $display("%0t est_y mismatch: expected %0d actual %0d",
                        $time, want.y, rsp_est_y);
               error_count++;
            end
         end
      end
   end

   // watchdog: too long without any beat or register write
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t timeout, %0d estimates still owed", $time, pending_estimates.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_seq_number = '0;
      req_meas_x     = '0;
      req_meas_y     = '0;
      csr_write_en   = 1'b0;
      csr_index      = ksm_pkg::CSR_PROCESS_NOISE;
      csr_wdata      = '0;
      flt_q          = ksm_pkg::Q_RESET;
      flt_r          = ksm_pkg::R_RESET;
      flt_prev_seq   = ksm_pkg::PREV_SEQ_RESET;
      flt_est_x      = '0;
      flt_est_y      = '0;
      flt_var_x      = ksm_pkg::VAR_ONE;
      flt_var_y      = ksm_pkg::VAR_ONE;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_sequence_gaps();
      test_position_rails();
      test_gain_clamp();
      test_random_tracks();

      // let any stray result show up before judging
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d position beats, %0d estimates checked, %0d noise writes",
               reports_sent, results_seen, register_writes);
      $display("including %0d track reloads and %0d clamped gains", reload_count, clamp_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/ksm_pkg.sv
design/ksm_div.sv
design/ksm_mul.sv
design/two_axis_scalar_kalman_smoother_core.sv
test/two_axis_scalar_kalman_smoother_core_tb.sv
